FILE: hw/rtl/drps_pkg.sv
// ----------------------------------------------------------------------------
// drps_pkg
// Shared constants, tables and types of the dead-reckoning position step.
// ----------------------------------------------------------------------------
package drps_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_N = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

	localparam logic [20:0] DIST_KQ = 21'd1987071;
	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
	localparam logic signed [32:0] COS_FLOOR = 33'sd1074;

	localparam logic [15:0] CRS_FULL = 16'd36000;
	localparam logic [15:0] CRS_3QTR = 16'd27000;
	localparam logic [15:0] CRS_HALF = 16'd18000;
	localparam logic [15:0] CRS_QTR = 16'd9000;
	localparam logic [17:0] CRS_PI_INT = 18'd187403;
	localparam logic [12:0] CRS_PI_REM = 13'd5426;
	localparam logic [22:0] CRS_RECIP = 23'd7635498;

	localparam logic signed [32:0] LAT_HALF = 33'sd1800000000;
	localparam logic signed [32:0] LAT_QTR = 33'sd900000000;
	localparam logic [30:0] LAT_PI_REM = 31'd1573259426;
	localparam logic [31:0] LAT_RECIP = 32'd3753943213;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
		30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

	localparam int DIV_NW = 61;
	localparam int DIV_DW = 31;
	localparam int TAG_W = 157;

	typedef logic [TAG_W-1:0] drps_tag_t;

endpackage

FILE: hw/rtl/drps_in_if.sv
// ----------------------------------------------------------------------------
// drps_in_if
// Request channel carrying the current position, speed, course and step.
// ----------------------------------------------------------------------------
interface drps_in_if;

	logic valid;
	logic ready;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic [13:0] speed;
	logic [15:0] course;
	logic [15:0] step_ms;

	modport source (
		output valid, latitude, longitude, speed, course, step_ms,
		input ready
	);

	modport sink (
		input valid, latitude, longitude, speed, course, step_ms,
		output ready
	);

endinterface

FILE: hw/rtl/drps_out_if.sv
// ----------------------------------------------------------------------------
// drps_out_if
// Result channel carrying the updated position and the saturation flag.
// ----------------------------------------------------------------------------
interface drps_out_if;

	logic valid;
	logic ready;
	logic signed [31:0] new_latitude;
	logic signed [31:0] new_longitude;
	logic saturated;

	modport source (
		output valid, new_latitude, new_longitude, saturated,
		input ready
	);

	modport sink (
		input valid, new_latitude, new_longitude, saturated,
		output ready
	);

endinterface

FILE: hw/rtl/dead_reckoning_position_step.sv
// ----------------------------------------------------------------------------
// dead_reckoning_position_step
// Flat-earth dead-reckoning update of a position in fixed point.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel with latitude, longitude, speed, course
// and time step; each gives exactly one result on the result channel with the
// new latitude, new longitude and a flag that is set when either was clipped.
// The block is a single pipeline of 76 + 2 * CORDIC_N register stages: two
// pipelined CORDIC rotators of one iteration per stage and the pipelined
// longitude divider of one quotient bit per stage (61) set that figure. A new
// request is taken in every cycle while the output is not stalled, so the
// throughput is one item per clock.
// The whole pipeline advances together. When the receiver holds ready low
// while a result is waiting, every stage holds and item.ready drops; nothing
// is lost or repeated, and a bubble at the output lets the pipeline move on.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module dead_reckoning_position_step
	import drps_pkg::*;
(
	input logic clk,
	input logic arst_n,
	drps_in_if.sink item,
	drps_out_if.source result
);

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} xyz_t;

	typedef struct packed {
		logic [26:0]        dd;
		logic               nrc;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
	} c1_side_t;

	typedef struct packed {
		logic               nr;
		logic signed [32:0] lat_r;
		logic signed [31:0] lon;
		logic signed [59:0] num;
	} c2_side_t;

	typedef struct packed {
		logic signed [32:0] lat_r;
		logic signed [31:0] lon;
		logic signed [59:0] num;
		logic [29:0]        m;
		logic               na;
		logic               nr;
	} tag1_t;

	typedef struct packed {
		logic signed [32:0] lat_r;
		logic signed [31:0] lon;
		logic               sgn;
	} tag2_t;

	function automatic xyz_t cordic_step(input xyz_t v, input logic [4:0] idx);
		xyz_t r;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] at;
		dx = v.y >>> idx;
		dy = v.x >>> idx;
		at = $signed(33'(ATAN_Q30[idx]));
		if (!v.z[32]) begin
			r.x = v.x - dx;
			r.y = v.y + dy;
			r.z = v.z - at;
		end else begin
			r.x = v.x + dx;
			r.y = v.y - dy;
			r.z = v.z + at;
		end
		return r;
	endfunction

	logic en;

	// Stage 1: speed times step, course folded into a quarter turn.
	logic [15:0] crs_red;
	logic [13:0] mc;
	logic        nac;
	logic        nrc;

	logic               v_s1;
	logic [29:0]        p_s1;
	logic [13:0]        mc_s1;
	logic               nac_s1;
	logic               nrc_s1;
	logic signed [30:0] lat_s1;
	logic signed [31:0] lon_s1;

	logic        v_s2;
	logic [26:0] dd_raw;
	logic [51:0] ddp;
	logic [30:0] mq_s2;
	logic [25:0] xr_s2;
	logic        nac_s2;
	c1_side_t    side_s2;

	logic        v_s3;
	logic [44:0] prod_s3;
	logic [30:0] mq_s3;
	logic        nac_s3;
	c1_side_t    side_s3;

	logic               v_s4;
	logic [31:0]        zmag1;
	xyz_t               xyz_s4;
	c1_side_t           side_s4;

	logic     c1_v    [CORDIC_N];
	xyz_t     c1_xyz  [CORDIC_N];
	c1_side_t c1_side [CORDIC_N];

	logic signed [32:0] ch;
	logic signed [32:0] sh;

	logic               v_s5;
	logic signed [60:0] prodc_s5;
	logic signed [59:0] num_s5;
	logic signed [30:0] lat_s5;
	logic signed [31:0] lon_s5;

	logic               v_s6;
	logic signed [31:0] t_s6;
	logic signed [59:0] num_s6;
	logic signed [30:0] lat_s6;
	logic signed [31:0] lon_s6;

	logic               v_s7;
	logic signed [32:0] latr_s7;
	logic signed [59:0] num_s7;
	logic signed [31:0] lon_s7;

	logic signed [32:0] lr_fold;
	logic               nr2;

	logic               v_s8;
	logic [29:0]        m2_s8;
	logic               na2_s8;
	logic               nr2_s8;
	logic signed [32:0] latr_s8;
	logic signed [59:0] num_s8;
	logic signed [31:0] lon_s8;

	logic        v_s9;
	logic [60:0] x2_s9;
	logic [30:0] qe_s9;
	tag1_t       t1_s9;

	logic               v_s10;
	logic signed [61:0] r_s10;
	logic [30:0]        qe_s10;
	tag1_t              t1_s10;

	logic [30:0] qc;
	logic [30:0] zmag2;

	logic     v_s11;
	xyz_t     xyz_s11;
	c2_side_t side_s11;

	logic     c2_v    [CORDIC_N];
	xyz_t     c2_xyz  [CORDIC_N];
	c2_side_t c2_side [CORDIC_N];

	logic signed [32:0] clr;

	logic               v_s12;
	logic signed [32:0] cl_s12;
	logic [58:0]        anum_s12;
	logic               nneg_s12;
	logic signed [32:0] latr_s12;
	logic signed [31:0] lon_s12;

	logic [30:0] acl;

	logic        v_s13;
	logic [60:0] dvd_s13;
	logic [30:0] dsr_s13;
	tag2_t       t2_s13;

	logic              dv2;
	logic [DIV_NW-1:0] q2;
	drps_tag_t         tg2;
	tag2_t             t2_out;
	logic signed [50:0] qs;

	logic               v_s14;
	logic signed [42:0] t2q_s14;
	logic signed [32:0] latr_s14;
	logic signed [31:0] lon_s14;

	logic signed [43:0] lonr;
	logic               lat_hi;
	logic               lat_lo;
	logic               lon_hi;
	logic               lon_lo;

	logic               v_s15;
	logic signed [31:0] lat_out_s15;
	logic signed [31:0] lon_out_s15;
	logic               sat_s15;

	assign en = !v_s15 || result.ready;
	assign item.ready = en;

	assign crs_red = (item.course >= CRS_FULL) ? item.course - CRS_FULL : item.course;

	always_comb begin
		if (crs_red <= CRS_QTR) begin
			mc = 14'(crs_red);
			nac = 1'b0;
			nrc = 1'b0;
		end else if (crs_red <= CRS_HALF) begin
			mc = 14'(CRS_HALF - crs_red);
			nac = crs_red < CRS_HALF;
			nrc = 1'b1;
		end else if (crs_red < CRS_3QTR) begin
			mc = 14'(crs_red - CRS_HALF);
			nac = 1'b0;
			nrc = 1'b1;
		end else begin
			mc = 14'(CRS_FULL - crs_red);
			nac = 1'b1;
			nrc = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= c1_v[CORDIC_N-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= c2_v[CORDIC_N-1];
			v_s13 <= v_s12;
			v_s14 <= dv2;
			v_s15 <= v_s14;
		end
	end

	assign ddp = 52'(p_s1) * 52'(DIST_KQ) + 52'(24'h800000);
	assign dd_raw = ddp[50:24];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= 30'(item.speed) * 30'(item.step_ms);
			mc_s1 <= mc;
			nac_s1 <= nac;
			nrc_s1 <= nrc;
			lat_s1 <= item.latitude;
			lon_s1 <= item.longitude;

			mq_s2 <= 31'(mc_s1) * 31'(CRS_PI_INT);
			xr_s2 <= 26'(mc_s1) * 26'(CRS_PI_REM) + 26'(CRS_QTR);
			nac_s2 <= nac_s1;
			side_s2.dd <= dd_raw;
			side_s2.nrc <= nrc_s1;
			side_s2.lat <= lat_s1;
			side_s2.lon <= lon_s1;

			prod_s3 <= 45'(xr_s2[25:4]) * 45'(CRS_RECIP);
			mq_s3 <= mq_s2;
			nac_s3 <= nac_s2;
			side_s3 <= side_s2;

			xyz_s4.x <= CORDIC_X0;
			xyz_s4.y <= '0;
			xyz_s4.z <= nac_s3 ? -$signed(33'(zmag1)) : $signed(33'(zmag1));
			side_s4 <= side_s3;
		end
	end

	assign zmag1 = 32'(mq_s3) + 32'(prod_s3[44:33]);

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic1
		logic     pv;
		xyz_t     pxyz;
		c1_side_t pside;

		if (i == 0) begin : g_first
			assign pv = v_s4;
			assign pxyz = xyz_s4;
			assign pside = side_s4;
		end else begin : g_next
			assign pv = c1_v[i-1];
			assign pxyz = c1_xyz[i-1];
			assign pside = c1_side[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c1_v[i] <= 1'b0;
			end else if (en) begin
				c1_v[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c1_xyz[i] <= cordic_step(pxyz, 5'(i));
				c1_side[i] <= pside;
			end
		end
	end

	assign ch = c1_side[CORDIC_N-1].nrc ? -c1_xyz[CORDIC_N-1].x : c1_xyz[CORDIC_N-1].x;
	assign sh = c1_side[CORDIC_N-1].nrc ? -c1_xyz[CORDIC_N-1].y : c1_xyz[CORDIC_N-1].y;

	always_comb begin
		if (latr_s7 > LAT_QTR) begin
			lr_fold = latr_s7 - LAT_HALF;
			nr2 = 1'b1;
		end else if (latr_s7 < -LAT_QTR) begin
			lr_fold = latr_s7 + LAT_HALF;
			nr2 = 1'b1;
		end else begin
			lr_fold = latr_s7;
			nr2 = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prodc_s5 <= 61'($signed({1'b0, c1_side[CORDIC_N-1].dd})) * 61'(ch);
			num_s5 <= 60'($signed({1'b0, c1_side[CORDIC_N-1].dd})) * 60'(sh);
			lat_s5 <= c1_side[CORDIC_N-1].lat;
			lon_s5 <= c1_side[CORDIC_N-1].lon;

			t_s6 <= 32'((prodc_s5 + 61'sd536870912) >>> 30);
			num_s6 <= num_s5;
			lat_s6 <= lat_s5;
			lon_s6 <= lon_s5;

			latr_s7 <= 33'(lat_s6) + 33'((t_s6 + 32'sd128) >>> 8);
			num_s7 <= num_s6;
			lon_s7 <= lon_s6;

			m2_s8 <= 30'(lr_fold[32] ? -lr_fold : lr_fold);
			na2_s8 <= lr_fold[32];
			nr2_s8 <= nr2;
			latr_s8 <= latr_s7;
			num_s8 <= num_s7;
			lon_s8 <= lon_s7;

			x2_s9 <= 61'(m2_s8) * 61'(LAT_PI_REM) + 61'(LAT_QTR);
			qe_s9 <= 31'((63'(m2_s8) * 63'(LAT_RECIP) + 63'(32'h80000000)) >> 32);
			t1_s9.lat_r <= latr_s8;
			t1_s9.lon <= lon_s8;
			t1_s9.num <= num_s8;
			t1_s9.m <= m2_s8;
			t1_s9.na <= na2_s8;
			t1_s9.nr <= nr2_s8;

			r_s10 <= $signed(62'(x2_s9) - 62'(qe_s9) * 62'(LAT_HALF));
			qe_s10 <= qe_s9;
			t1_s10 <= t1_s9;
		end
	end

	// The reciprocal estimate is within one of the quotient; the remainder fixes it.
	always_comb begin
		if (r_s10[61]) begin
			qc = qe_s10 - 31'd1;
		end else if (r_s10 >= 62'(LAT_HALF)) begin
			qc = qe_s10 + 31'd1;
		end else begin
			qc = qe_s10;
		end
	end

	assign zmag2 = 31'(t1_s10.m) + qc;

	always_ff @(posedge clk) begin
		if (en) begin
			xyz_s11.x <= CORDIC_X0;
			xyz_s11.y <= '0;
			xyz_s11.z <= t1_s10.na ? -$signed(33'(zmag2)) : $signed(33'(zmag2));
			side_s11.nr <= t1_s10.nr;
			side_s11.lat_r <= t1_s10.lat_r;
			side_s11.lon <= t1_s10.lon;
			side_s11.num <= t1_s10.num;
		end
	end

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic2
		logic     pv;
		xyz_t     pxyz;
		c2_side_t pside;

		if (i == 0) begin : g_first
			assign pv = v_s11;
			assign pxyz = xyz_s11;
			assign pside = side_s11;
		end else begin : g_next
			assign pv = c2_v[i-1];
			assign pxyz = c2_xyz[i-1];
			assign pside = c2_side[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c2_v[i] <= 1'b0;
			end else if (en) begin
				c2_v[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c2_xyz[i] <= cordic_step(pxyz, 5'(i));
				c2_side[i] <= pside;
			end
		end
	end

	always_comb begin
		clr = c2_side[CORDIC_N-1].nr ? -c2_xyz[CORDIC_N-1].x : c2_xyz[CORDIC_N-1].x;
		if (clr < COS_FLOOR && clr > -COS_FLOOR) begin
			clr = COS_FLOOR;
		end
	end

	assign acl = 31'(cl_s12[32] ? -cl_s12 : cl_s12);

	always_ff @(posedge clk) begin
		if (en) begin
			cl_s12 <= clr;
			anum_s12 <= 59'(c2_side[CORDIC_N-1].num[59] ?
				-c2_side[CORDIC_N-1].num : c2_side[CORDIC_N-1].num);
			nneg_s12 <= c2_side[CORDIC_N-1].num[59];
			latr_s12 <= c2_side[CORDIC_N-1].lat_r;
			lon_s12 <= c2_side[CORDIC_N-1].lon;

			dvd_s13 <= 61'(anum_s12) + 61'(acl[30:1]);
			dsr_s13 <= acl;
			t2_s13.lat_r <= latr_s12;
			t2_s13.lon <= lon_s12;
			t2_s13.sgn <= nneg_s12 ^ cl_s12[32];
		end
	end

	drps_div u_div_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s13),
		.dividend  (dvd_s13),
		.divisor   (dsr_s13),
		.tag_in    ({{(TAG_W - $bits(tag2_t)){1'b0}}, t2_s13}),
		.out_valid (dv2),
		.quotient  (q2),
		.tag_out   (tg2)
	);

	assign t2_out = tag2_t'(tg2[$bits(tag2_t)-1:0]);
	assign qs = t2_out.sgn ? -$signed({1'b0, q2[49:0]}) : $signed({1'b0, q2[49:0]});

	assign lonr = 44'(lon_s14) + 44'(t2q_s14);
	assign lat_hi = latr_s14 > 33'sd2147483647;
	assign lat_lo = latr_s14 < -33'sd2147483648;
	assign lon_hi = lonr > 44'sd2147483647;
	assign lon_lo = lonr < -44'sd2147483648;

	always_ff @(posedge clk) begin
		if (en) begin
			t2q_s14 <= 43'((qs + 51'sd128) >>> 8);
			latr_s14 <= t2_out.lat_r;
			lon_s14 <= t2_out.lon;

			if (lat_hi) begin
				lat_out_s15 <= 32'sh7FFFFFFF;
			end else if (lat_lo) begin
				lat_out_s15 <= 32'sh80000000;
			end else begin
				lat_out_s15 <= 32'(latr_s14);
			end
			if (lon_hi) begin
				lon_out_s15 <= 32'sh7FFFFFFF;
			end else if (lon_lo) begin
				lon_out_s15 <= 32'sh80000000;
			end else begin
				lon_out_s15 <= 32'(lonr);
			end
			sat_s15 <= lat_hi || lat_lo || lon_hi || lon_lo;
		end
	end

	assign result.valid = v_s15;
	assign result.new_latitude = lat_out_s15;
	assign result.new_longitude = lon_out_s15;
	assign result.saturated = sat_s15;

endmodule

FILE: hw/rtl/drps_div.sv
// ----------------------------------------------------------------------------
// drps_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module drps_div
	import drps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	input  drps_tag_t         tag_in,
	output logic              out_valid,
	output logic [DIV_NW-1:0] quotient,
	output drps_tag_t         tag_out
);

	logic              vld_s [DIV_NW];
	logic [DIV_DW-1:0] rem_s [DIV_NW];
	logic [DIV_NW-1:0] dvd_s [DIV_NW];
	logic [DIV_NW-1:0] quo_s [DIV_NW];
	logic [DIV_DW-1:0] dsr_s [DIV_NW];
	drps_tag_t         tag_s [DIV_NW];

	for (genvar k = 0; k < DIV_NW; k++) begin : g_stage
		logic              pv;
		logic [DIV_DW-1:0] prem;
		logic [DIV_NW-1:0] pdvd;
		logic [DIV_NW-1:0] pquo;
		logic [DIV_DW-1:0] pdsr;
		drps_tag_t         ptag;
		logic [DIV_DW:0]   trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign prem = '0;
			assign pdvd = dividend;
			assign pquo = '0;
			assign pdsr = divisor;
			assign ptag = tag_in;
		end else begin : g_next
			assign pv = vld_s[k-1];
			assign prem = rem_s[k-1];
			assign pdvd = dvd_s[k-1];
			assign pquo = quo_s[k-1];
			assign pdsr = dsr_s[k-1];
			assign ptag = tag_s[k-1];
		end

		assign trial = {prem, pdvd[DIV_NW-1]};
		assign ge = trial >= {1'b0, pdsr};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DIV_DW'(trial - {1'b0, pdsr}) : DIV_DW'(trial);
				dvd_s[k] <= pdvd << 1;
				quo_s[k] <= {pquo[DIV_NW-2:0], ge};
				dsr_s[k] <= pdsr;
				tag_s[k] <= ptag;
			end
		end
	end

	assign out_valid = vld_s[DIV_NW-1];
	assign quotient = quo_s[DIV_NW-1];
	assign tag_out = tag_s[DIV_NW-1];

endmodule
